[rtl/line_sensor_junction_tracker_assert.svh]
// Assertion macros shared by the tracker RTL.
// Each macro expects signals named clk and arst_n in the scope where it is used.
`ifndef LINE_SENSOR_JUNCTION_TRACKER_ASSERT_SVH
`define LINE_SENSOR_JUNCTION_TRACKER_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define LSJT_ASSERT_SAME(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("lsjt: check failed");

// The consequent must hold in the cycle after the antecedent.
`define LSJT_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("lsjt: check failed");

`endif

[rtl/lsjt_pkg.sv]
package lsjt_pkg;

	localparam int unsigned SampleW  = 12;
	localparam int unsigned CountW   = 16;
	localparam int unsigned NumSens  = 4;
	localparam int unsigned CfgIdxW  = 8;

	localparam logic [SampleW-1:0] BlackReset = 12'd1638;
	localparam logic [SampleW-1:0] WhiteReset = 12'd2867;

	typedef enum logic [CfgIdxW-1:0] {
		REG_BLACK_LEVEL = 8'd0,
		REG_WHITE_LEVEL = 8'd1
	} lsjt_reg_t;

	typedef enum logic [1:0] {
		EV_NONE  = 2'd0,
		EV_NODE  = 2'd1,
		EV_RIGHT = 2'd2,
		EV_LEFT  = 2'd3
	} lsjt_event_t;

	typedef enum logic [1:0] {
		HEAD_NORTH = 2'd0,
		HEAD_EAST  = 2'd1,
		HEAD_SOUTH = 2'd2,
		HEAD_WEST  = 2'd3
	} lsjt_heading_t;

	typedef enum logic [3:0] {
		MODE_IDLE  = 4'b0001,
		MODE_NODE  = 4'b0010,
		MODE_RIGHT = 4'b0100,
		MODE_LEFT  = 4'b1000
	} lsjt_mode_t;

	typedef struct packed {
		logic [SampleW-1:0] sensor_a;
		logic [SampleW-1:0] sensor_b;
		logic [SampleW-1:0] sensor_c;
		logic [SampleW-1:0] sensor_d;
	} lsjt_in_t;

	typedef struct packed {
		logic [1:0]        event_code;
		logic [1:0]        heading;
		logic [CountW-1:0] node_total;
		logic [CountW-1:0] left_total;
		logic [CountW-1:0] right_total;
	} lsjt_out_t;

	// Per-frame threshold results, index 0 is the outermost left sensor.
	typedef struct packed {
		logic [NumSens-1:0] white;
		logic [NumSens-1:0] black;
		logic               node_exit;
	} lsjt_flags_t;

	function automatic logic [CountW-1:0] sat_inc(input logic [CountW-1:0] v);
		return (&v) ? v : v + CountW'(1);
	endfunction

endpackage

[rtl/lsjt_classify.sv]
module lsjt_classify
	import lsjt_pkg::*;
(
	input  lsjt_in_t           frame,
	input  logic [SampleW-1:0] black_level,
	input  logic [SampleW-1:0] white_level,
	output lsjt_flags_t        flags
);

	logic [SampleW-1:0] samp [NumSens];

	assign samp[0] = frame.sensor_a;
	assign samp[1] = frame.sensor_b;
	assign samp[2] = frame.sensor_c;
	assign samp[3] = frame.sensor_d;

	always_comb begin
		for (int i = 0; i < NumSens; i++) begin
			flags.white[i] = samp[i] > white_level;
			flags.black[i] = samp[i] < black_level;
		end
		// A node is left once both outer sensors fall under the white level.
		flags.node_exit = (samp[0] < white_level) && (samp[3] < white_level);
	end

endmodule

[rtl/lsjt_tracker.sv]
module lsjt_tracker
	import lsjt_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        step,
	input  lsjt_flags_t flags,
	input  logic        take,
	output logic        res_valid,
	output lsjt_out_t   res
);

	lsjt_mode_t        mode_q, mode_d;
	logic [1:0]        facing_q, facing_d;
	logic [CountW-1:0] nodes_q, nodes_d;
	logic [CountW-1:0] lefts_q, lefts_d;
	logic [CountW-1:0] rights_q, rights_d;
	logic [1:0]        ev_d;
	logic              all_white, turn_end;

	assign all_white = &flags.white;
	assign turn_end  = flags.black[0] && flags.white[1] && flags.white[2] && flags.black[3];

	always_comb begin
		mode_d   = mode_q;
		facing_d = facing_q;
		nodes_d  = nodes_q;
		lefts_d  = lefts_q;
		rights_d = rights_q;
		ev_d     = EV_NONE;
		case (mode_q)
			MODE_IDLE: begin
				if (all_white) begin
					mode_d = MODE_NODE;
				end else if (flags.white[1] && flags.white[2] && flags.white[3]) begin
					mode_d = MODE_RIGHT;
				end else if (flags.white[0] && flags.white[1] && flags.white[2]) begin
					mode_d = MODE_LEFT;
				end
			end
			MODE_NODE: begin
				if (flags.node_exit) begin
					nodes_d = sat_inc(nodes_q);
					ev_d    = EV_NODE;
					mode_d  = MODE_IDLE;
				end
			end
			MODE_RIGHT: begin
				if (turn_end) begin
					rights_d = sat_inc(rights_q);
					facing_d = facing_q + 2'd1;
					ev_d     = EV_RIGHT;
					mode_d   = MODE_IDLE;
				end else if (all_white) begin
					mode_d = MODE_IDLE;
				end
			end
			MODE_LEFT: begin
				// Subtracting one wraps north round to west.
				if (turn_end) begin
					lefts_d  = sat_inc(lefts_q);
					facing_d = facing_q - 2'd1;
					ev_d     = EV_LEFT;
					mode_d   = MODE_IDLE;
				end else if (all_white) begin
					mode_d = MODE_IDLE;
				end
			end
			default: begin
				mode_d = MODE_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q    <= MODE_IDLE;
			facing_q  <= HEAD_NORTH;
			nodes_q   <= '0;
			lefts_q   <= '0;
			rights_q  <= '0;
			res_valid <= 1'b0;
		end else begin
			if (step) begin
				mode_q    <= mode_d;
				facing_q  <= facing_d;
				nodes_q   <= nodes_d;
				lefts_q   <= lefts_d;
				rights_q  <= rights_d;
				res_valid <= 1'b1;
			end else if (take) begin
				res_valid <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			res.event_code  <= ev_d;
			res.heading     <= facing_d;
			res.node_total  <= nodes_d;
			res.left_total  <= lefts_d;
			res.right_total <= rights_d;
		end
	end

endmodule

[rtl/line_sensor_junction_tracker.sv]
// Channel   Handshake                Payload
// in        in_valid / in_ready      in_data   (lsjt_in_t, four 12-bit samples)
// out       out_valid / out_ready    out_data  (lsjt_out_t, event, heading, totals)
// cfg       cfg_valid / cfg_ready    cfg_index, cfg_data (always ready)
//
// One frame per cycle unless the result stalls; accepted frames enter the input register.
// The input register feeds the compares and the state update, which load the result register.
// Reset clears the handshake state, the mode, heading and counters and loads default levels.
// A stalled result holds the input register; at most two frames are held inside the block.
`include "line_sensor_junction_tracker_assert.svh"

module line_sensor_junction_tracker
	import lsjt_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  lsjt_in_t           in_data,
	output logic               out_valid,
	input  logic               out_ready,
	output lsjt_out_t          out_data,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [CfgIdxW-1:0] cfg_index,
	input  logic [SampleW-1:0] cfg_data
);

	logic [SampleW-1:0] black_q, white_q;
	lsjt_in_t           frame_s1;
	logic               valid_s1;
	logic               advance;
	lsjt_flags_t        flags;

	assign cfg_ready = 1'b1;
	assign advance   = valid_s1 && (!out_valid || out_ready);
	assign in_ready  = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			black_q <= BlackReset;
			white_q <= WhiteReset;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_BLACK_LEVEL: black_q <= cfg_data;
				REG_WHITE_LEVEL: white_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			frame_s1 <= in_data;
		end
	end

	lsjt_classify u_classify (
		.frame       (frame_s1),
		.black_level (black_q),
		.white_level (white_q),
		.flags       (flags)
	);

	lsjt_tracker u_tracker (
		.clk       (clk),
		.arst_n    (arst_n),
		.step      (advance),
		.flags     (flags),
		.take      (out_ready),
		.res_valid (out_valid),
		.res       (out_data)
	);

	// Every frame that leaves the input register lands in the result register.
	`LSJT_ASSERT_NEXT(a_step_loads_result, advance, out_valid)
	// A frame blocked by a waiting result stays in the input register.
	`LSJT_ASSERT_NEXT(a_s1_holds, valid_s1 && !advance, valid_s1 && $stable(frame_s1))
	// A finished event is always reflected in a non-zero total, since totals saturate.
	`LSJT_ASSERT_SAME(a_node_counted,
		out_valid && out_data.event_code == EV_NODE, out_data.node_total != '0)
	`LSJT_ASSERT_SAME(a_turn_counted,
		out_valid && (out_data.event_code == EV_RIGHT || out_data.event_code == EV_LEFT),
		out_data.right_total != '0 || out_data.left_total != '0)

endmodule

[sim/testbench.sv]
module testbench;
	import lsjt_pkg::*;

	localparam int FullScale  = 4095;
	localparam int StallLimit = 1000;

	typedef struct packed {
		logic               is_cfg;
		logic [CfgIdxW-1:0] idx;
		logic [SampleW-1:0] value;
		lsjt_in_t           frame;
	} plan_op_t;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               in_valid = 1'b0;
	logic               in_ready;
	lsjt_in_t           in_data = '0;
	logic               out_valid;
	logic               out_ready = 1'b0;
	lsjt_out_t          out_data;
	logic               cfg_valid = 1'b0;
	logic               cfg_ready;
	logic [CfgIdxW-1:0] cfg_index = '0;
	logic [SampleW-1:0] cfg_data = '0;

	line_sensor_junction_tracker uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	plan_op_t  frame_plan[$];
	lsjt_out_t due_results[$];

	// Thresholds as they will stand when the planned frames reach the block.
	int gen_black = BlackReset;
	int gen_white = WhiteReset;

	// Tracker state mirrored from accepted transactions.
	logic [SampleW-1:0] lvl_black = BlackReset;
	logic [SampleW-1:0] lvl_white = WhiteReset;
	lsjt_mode_t         trk_mode = MODE_IDLE;
	lsjt_heading_t      trk_head = HEAD_NORTH;
	logic [CountW-1:0]  cnt_node = '0;
	logic [CountW-1:0]  cnt_left = '0;
	logic [CountW-1:0]  cnt_right = '0;

	int          mismatches = 0;
	int          frames_taken = 0;
	int          regs_written = 0;
	int          results_seen = 0;
	int          event_tally[4] = '{0, 0, 0, 0};
	int          frames_in_flight = 0;
	int          quiet_cycles = 0;
	int unsigned cyc = 0;

	always @(negedge clk) begin
		cyc <= cyc + 1;
	end

	// Roughly nine idle cycles in a hundred, except in a long calm window of every period.
	function automatic bit take_break();
		return (cyc % 5000 >= 1200) && ($urandom_range(99) < 9);
	endfunction

	function automatic lsjt_out_t track_frame(input lsjt_in_t f);
		logic [NumSens-1:0] wht;
		logic [NumSens-1:0] blk;
		lsjt_out_t          r;
		wht = {f.sensor_d > lvl_white, f.sensor_c > lvl_white,
			f.sensor_b > lvl_white, f.sensor_a > lvl_white};
		blk = {f.sensor_d < lvl_black, f.sensor_c < lvl_black,
			f.sensor_b < lvl_black, f.sensor_a < lvl_black};
		r.event_code = EV_NONE;
		case (trk_mode)
			MODE_IDLE: begin
				if (&wht)
					trk_mode = MODE_NODE;
				else if (&wht[3:1])
					trk_mode = MODE_RIGHT;
				else if (&wht[2:0])
					trk_mode = MODE_LEFT;
			end
			MODE_NODE: begin
				if (f.sensor_a < lvl_white && f.sensor_d < lvl_white) begin
					if (cnt_node != '1)
						cnt_node = cnt_node + 1'b1;
					r.event_code = EV_NODE;
					trk_mode = MODE_IDLE;
				end
			end
			default: begin
				if (blk[0] && wht[1] && wht[2] && blk[3]) begin
					if (trk_mode == MODE_RIGHT) begin
						if (cnt_right != '1)
							cnt_right = cnt_right + 1'b1;
						trk_head = lsjt_heading_t'(trk_head + 2'd1);
						r.event_code = EV_RIGHT;
					end else begin
						if (cnt_left != '1)
							cnt_left = cnt_left + 1'b1;
						trk_head = lsjt_heading_t'(trk_head - 2'd1);
						r.event_code = EV_LEFT;
					end
					trk_mode = MODE_IDLE;
				end else if (&wht) begin
					// An all-white frame drops the turn and is not classified again.
					trk_mode = MODE_IDLE;
				end
			end
		endcase
		r.heading     = trk_head;
		r.node_total  = cnt_node;
		r.left_total  = cnt_left;
		r.right_total = cnt_right;
		return r;
	endfunction

	function automatic void push_frame(input logic [SampleW-1:0] a, b, c, d);
		plan_op_t op;
		op = '0;
		op.frame.sensor_a = a;
		op.frame.sensor_b = b;
		op.frame.sensor_c = c;
		op.frame.sensor_d = d;
		frame_plan.push_back(op);
	endfunction

	function automatic void push_reg(input logic [CfgIdxW-1:0] idx, input logic [SampleW-1:0] value);
		plan_op_t op;
		op = '0;
		op.is_cfg = 1'b1;
		op.idx = idx;
		op.value = value;
		frame_plan.push_back(op);
		if (idx == REG_BLACK_LEVEL)
			gen_black = value;
		else if (idx == REG_WHITE_LEVEL)
			gen_white = value;
	endfunction

	function automatic logic [SampleW-1:0] pick_under(input int lim);
		return SampleW'($urandom_range(lim, 0));
	endfunction

	function automatic logic [SampleW-1:0] pick_over(input int lim);
		return SampleW'($urandom_range(FullScale, lim));
	endfunction

	function automatic logic [SampleW-1:0] pick_white();
		return (gen_white >= FullScale) ? SampleW'(FullScale) : pick_over(gen_white + 1);
	endfunction

	function automatic logic [SampleW-1:0] pick_black();
		return (gen_black <= 0) ? '0 : pick_under(gen_black - 1);
	endfunction

	function automatic logic [SampleW-1:0] pick_any();
		return pick_under(FullScale);
	endfunction

	function automatic void node_run(input int holds);
		push_frame(pick_white(), pick_white(), pick_white(), pick_white());
		repeat (holds)
			push_frame(pick_over(gen_white), pick_any(), pick_any(), pick_any());
		push_frame(pick_under(gen_white > 0 ? gen_white - 1 : 0), pick_any(), pick_any(),
			pick_under(gen_white > 0 ? gen_white - 1 : 0));
	endfunction

	function automatic void turn_run(input bit go_right, input int holds, input bit abandon);
		if (go_right)
			push_frame(pick_under(gen_white), pick_white(), pick_white(), pick_white());
		else
			push_frame(pick_white(), pick_white(), pick_white(), pick_under(gen_white));
		repeat (holds)
			push_frame(pick_any(), pick_any(), pick_any(), pick_any());
		if (abandon)
			push_frame(pick_white(), pick_white(), pick_white(), pick_white());
		else
			push_frame(pick_black(), pick_white(), pick_white(), pick_black());
	endfunction

	function automatic void rand_sequence();
		int pick;
		pick = $urandom_range(9);
		case (pick)
			0, 1, 2: node_run($urandom_range(2));
			3, 4:    turn_run(1'b1, $urandom_range(2), 1'b0);
			5, 6:    turn_run(1'b0, $urandom_range(2), 1'b0);
			7:       turn_run($urandom_range(1), $urandom_range(1), 1'b1);
			default: repeat ($urandom_range(3, 1))
				push_frame(pick_any(), pick_any(), pick_any(), pick_any());
		endcase
	endfunction

	// Driver: frames run back to back but for gaps; a cfg write waits for no frame in flight.
	always @(posedge clk) begin : driver
		bit in_acc;
		bit in_busy;
		bit cfg_busy;
		bit frame_go;
		bit reg_go;
		if (arst_n) begin
			in_acc = in_valid && in_ready;
			frames_in_flight = frames_in_flight + int'(in_acc) - int'(out_valid && out_ready);
			in_busy = in_valid && !in_acc;
			cfg_busy = cfg_valid && !cfg_ready;
			frame_go = 1'b0;
			reg_go = 1'b0;
			if (!in_busy && !cfg_busy && frame_plan.size() != 0) begin
				if (!frame_plan[0].is_cfg)
					frame_go = !take_break();
				else
					reg_go = (frames_in_flight == 0) && !take_break();
			end
			if (!in_busy)
				in_valid <= frame_go;
			if (!cfg_busy)
				cfg_valid <= reg_go;
			if (frame_go)
				in_data <= frame_plan[0].frame;
			if (reg_go) begin
				cfg_index <= frame_plan[0].idx;
				cfg_data <= frame_plan[0].value;
			end
			if (frame_go || reg_go)
				void'(frame_plan.pop_front());
		end
	end

	// Monitor: checks each result first, then records what this edge's transactions imply.
	always @(posedge clk) begin : monitor
		lsjt_out_t want;
		if (arst_n) begin
			out_ready <= !take_break();
			if (out_valid && out_ready) begin
				results_seen++;
				if (due_results.size() == 0) begin
					$error("result arrived with nothing expected: %h", out_data);
					mismatches++;
				end else begin
					want = due_results.pop_front();
					event_tally[out_data.event_code]++;
					if (out_data.event_code !== want.event_code) begin
						$error("event_code: expected %0d, got %0d", want.event_code,
							out_data.event_code);
						mismatches++;
					end
					if (out_data.heading !== want.heading) begin
						$error("heading: expected %0d, got %0d", want.heading, out_data.heading);
						mismatches++;
					end
					if (out_data.node_total !== want.node_total) begin
						$error("node_total: expected %0d, got %0d", want.node_total,
							out_data.node_total);
						mismatches++;
					end
					if (out_data.left_total !== want.left_total) begin
						$error("left_total: expected %0d, got %0d", want.left_total,
							out_data.left_total);
						mismatches++;
					end
					if (out_data.right_total !== want.right_total) begin
						$error("right_total: expected %0d, got %0d", want.right_total,
							out_data.right_total);
						mismatches++;
					end
				end
			end
			if (cfg_valid && cfg_ready) begin
				regs_written++;
				case (cfg_index)
					REG_BLACK_LEVEL: lvl_black = cfg_data;
					REG_WHITE_LEVEL: lvl_white = cfg_data;
					default: ;
				endcase
			end
			if (in_valid && in_ready) begin
				frames_taken++;
				due_results.push_back(track_frame(in_data));
			end
		end
	end

	always @(posedge clk) begin : watchdog
		if (arst_n) begin
			if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
				quiet_cycles <= 0;
			end else if (quiet_cycles == StallLimit) begin
				$error("no transaction for %0d cycles", StallLimit);
				$display("RESULT: ERROR");
				$finish;
			end else begin
				quiet_cycles <= quiet_cycles + 1;
			end
		end
	end

	initial begin : stimulus
		int setting;
		int base;
		int quota;
		int lvl;

		// Reset thresholds first, with samples sitting exactly on and beside each level.
		push_frame(12'h000, 12'h000, 12'h000, 12'h000);
		push_frame(12'hFFF, 12'hFFF, 12'hFFF, 12'hFFF);
		push_frame(12'd2867, 12'h000, 12'h000, 12'h000);
		push_frame(12'd2866, 12'hFFF, 12'hFFF, 12'd2866);
		push_frame(12'd2867, 12'd2868, 12'd2868, 12'd2868);
		push_frame(12'd1638, 12'hFFF, 12'hFFF, 12'h000);
		push_frame(12'd1637, 12'd2868, 12'd2868, 12'd1637);
		push_frame(12'hFFF, 12'hFFF, 12'hFFF, 12'd2867);
		push_frame(12'h000, 12'hFFF, 12'hFFF, 12'h000);
		// A second left turn takes the heading from north round to west.
		push_frame(12'hFFF, 12'hFFF, 12'hFFF, 12'h000);
		push_frame(12'h000, 12'hFFF, 12'hFFF, 12'h000);
		push_frame(12'h000, 12'hFFF, 12'hFFF, 12'hFFF);
		push_frame(12'hFFF, 12'hFFF, 12'hFFF, 12'hFFF);
		push_frame(12'hFFF, 12'hFFF, 12'hFFF, 12'hFFF);
		push_frame(12'h000, 12'h000, 12'h000, 12'h000);
		push_frame(12'h000, 12'hFFF, 12'hFFF, 12'hFFF);
		push_frame(12'h000, 12'hFFF, 12'hFFF, 12'h000);
		push_frame(12'hAAA, 12'h555, 12'hAAA, 12'h555);
		push_frame(12'h555, 12'hAAA, 12'h555, 12'hAAA);

		for (setting = 0; setting < 6; setting++) begin
			// A write to an unused index must leave both levels alone.
			push_reg(CfgIdxW'($urandom_range(255, int'(REG_WHITE_LEVEL) + 1)), pick_any());
			case (setting)
				0: begin
					push_reg(REG_BLACK_LEVEL, SampleW'($urandom_range(2000, 1000)));
					push_reg(REG_WHITE_LEVEL, SampleW'($urandom_range(3500, 2500)));
				end
				1: begin
					push_reg(REG_BLACK_LEVEL, SampleW'($urandom_range(FullScale, 2500)));
					push_reg(REG_WHITE_LEVEL, SampleW'($urandom_range(2000, 500)));
				end
				2: begin
					push_reg(REG_BLACK_LEVEL, '0);
					push_reg(REG_WHITE_LEVEL, SampleW'(FullScale));
				end
				3: begin
					push_reg(REG_BLACK_LEVEL, SampleW'(FullScale));
					push_reg(REG_WHITE_LEVEL, '0);
				end
				4: begin
					push_reg(REG_BLACK_LEVEL, pick_any());
					push_reg(REG_WHITE_LEVEL, pick_any());
				end
				default: begin
					lvl = $urandom_range(3000, 1000);
					push_reg(REG_WHITE_LEVEL, SampleW'(lvl));
					push_reg(REG_BLACK_LEVEL, SampleW'(lvl));
				end
			endcase
			base = frame_plan.size();
			quota = (setting == 2 || setting == 3) ? 60 : 200;
			while (frame_plan.size() - base < quota)
				rand_sequence();
		end

		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		while (frame_plan.size() != 0 || in_valid || cfg_valid || due_results.size() != 0)
			@(negedge clk);
		repeat (8) @(negedge clk);

		$display("Checked %0d results for %0d frames across %0d register writes.",
			results_seen, frames_taken, regs_written);
		$display("Events: %0d nodes, %0d right, %0d left; totals ended at %0d/%0d/%0d.",
			event_tally[EV_NODE], event_tally[EV_RIGHT], event_tally[EV_LEFT],
			cnt_node, cnt_right, cnt_left);
		if (mismatches == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule
